// ===== sv/lbn_pkg.sv =====
package lbn_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// Minimum frame lengths: IPv4 header end, UDP header end, TCP header end
	localparam logic [15:0] MIN_LEN_IPV4 = 16'd34;
	localparam logic [15:0] MIN_LEN_UDP  = 16'd42;
	localparam logic [15:0] MIN_LEN_TCP  = 16'd54;

	localparam logic [1:0] PORT_CLIENT    = 2'd0;
	localparam logic [1:0] PORT_BACKEND_A = 2'd1;
	localparam logic [1:0] PORT_BACKEND_B = 2'd2;

	localparam logic [31:0] RST_VIRTUAL_IP    = 32'h0A00_0001;
	localparam logic [31:0] RST_BACKEND_A_IP  = 32'h0A00_0002;
	localparam logic [31:0] RST_BACKEND_B_IP  = 32'h0A00_0003;
	localparam logic [47:0] RST_BACKEND_A_MAC = 48'hA036_9F1A_2DFC;
	localparam logic [47:0] RST_BACKEND_B_MAC = 48'hA036_9F1A_2DFE;

	typedef enum logic [2:0] {
		CFG_VIRTUAL_IP    = 3'd0,
		CFG_BACKEND_A_IP  = 3'd1,
		CFG_BACKEND_B_IP  = 3'd2,
		CFG_BACKEND_A_MAC = 3'd3,
		CFG_BACKEND_B_MAC = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] virtual_ip;
		logic [31:0] backend_a_ip;
		logic [31:0] backend_b_ip;
		logic [47:0] backend_a_mac;
		logic [47:0] backend_b_mac;
	} cfg_t;

	// One item in flight. Checksums and operands are kept byte-swapped
	// (memory view); op_a_m is added first, op_b_m (already inverted) second.
	typedef struct packed {
		logic        drop;
		logic [1:0]  egress;
		logic [47:0] dmac;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] ipc_m;
		logic [15:0] l4c_m;
		logic [31:0] op_a_m;
		logic [31:0] op_b_m;
	} item_t;

	function automatic logic [15:0] swap16(input logic [15:0] x);
		return {x[7:0], x[15:8]};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== sv/lbn_cfg_regs.sv =====
module lbn_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data,
	output lbn_pkg::cfg_t       cfg
);

	lbn_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.virtual_ip    <= lbn_pkg::RST_VIRTUAL_IP;
			cfg_q.backend_a_ip  <= lbn_pkg::RST_BACKEND_A_IP;
			cfg_q.backend_b_ip  <= lbn_pkg::RST_BACKEND_B_IP;
			cfg_q.backend_a_mac <= lbn_pkg::RST_BACKEND_A_MAC;
			cfg_q.backend_b_mac <= lbn_pkg::RST_BACKEND_B_MAC;
		end else if (cfg_valid) begin
			case (lbn_pkg::cfg_idx_t'(cfg_index))
				lbn_pkg::CFG_VIRTUAL_IP:    cfg_q.virtual_ip    <= cfg_data[31:0];
				lbn_pkg::CFG_BACKEND_A_IP:  cfg_q.backend_a_ip  <= cfg_data[31:0];
				lbn_pkg::CFG_BACKEND_B_IP:  cfg_q.backend_b_ip  <= cfg_data[31:0];
				lbn_pkg::CFG_BACKEND_A_MAC: cfg_q.backend_a_mac <= cfg_data;
				lbn_pkg::CFG_BACKEND_B_MAC: cfg_q.backend_b_mac <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/lbn_classify.sv =====
module lbn_classify (
	input  logic                clk,
	input  logic                load,
	input  lbn_pkg::cfg_t       cfg,
	input  logic [15:0]         frame_length,
	input  logic [7:0]          arrival_port,
	input  logic [47:0]         dest_mac,
	input  logic [15:0]         ether_type,
	input  logic [7:0]          ip_protocol,
	input  logic [15:0]         ip_header_checksum,
	input  logic [31:0]         source_address,
	input  logic [31:0]         destination_address,
	input  logic [15:0]         source_port,
	input  logic [15:0]         transport_checksum,
	output lbn_pkg::item_t      item
);

	logic           is_udp;
	logic           is_tcp;
	logic           drop_c;
	logic           server_side;
	logic           hash_odd;
	logic [31:0]    new_ip;
	logic [31:0]    old_ip;
	lbn_pkg::item_t item_c;
	lbn_pkg::item_t item_s1;

	assign is_udp = ip_protocol == lbn_pkg::PROTO_UDP;
	assign is_tcp = ip_protocol == lbn_pkg::PROTO_TCP;

	// The IPv4 length bound covers the Ethernet one.
	assign drop_c = (frame_length < lbn_pkg::MIN_LEN_IPV4)
		|| (ether_type != lbn_pkg::ETHERTYPE_IPV4)
		|| !((is_udp && frame_length >= lbn_pkg::MIN_LEN_UDP)
			|| (is_tcp && frame_length >= lbn_pkg::MIN_LEN_TCP));

	assign server_side = arrival_port != 8'd0;

	// FNV-1 multiplies by an odd prime, which keeps bit 0, and then xors in
	// the byte: the hash parity is the xor of bit 0 of every hashed byte.
	assign hash_odd = source_address[24] ^ source_address[16] ^ source_address[8]
		^ source_address[0] ^ source_port[8] ^ source_port[0] ^ ip_protocol[0];

	always_comb begin
		new_ip = hash_odd ? cfg.backend_b_ip : cfg.backend_a_ip;
		old_ip = destination_address;
		item_c.drop   = drop_c;
		item_c.egress = lbn_pkg::PORT_CLIENT;
		item_c.dmac   = dest_mac;
		item_c.saddr  = source_address;
		item_c.daddr  = destination_address;
		item_c.ipc_m  = lbn_pkg::swap16(ip_header_checksum);
		item_c.l4c_m  = lbn_pkg::swap16(transport_checksum);
		if (server_side) begin
			new_ip = cfg.virtual_ip;
			old_ip = source_address;
		end
		if (drop_c) begin
			// zero operands leave both checksums as received
			item_c.op_a_m = 32'd0;
			item_c.op_b_m = 32'd0;
		end else begin
			item_c.op_a_m = lbn_pkg::swap32(old_ip);
			item_c.op_b_m = ~lbn_pkg::swap32(new_ip);
			if (server_side) begin
				item_c.saddr = cfg.virtual_ip;
			end else begin
				item_c.daddr  = new_ip;
				item_c.dmac   = hash_odd ? cfg.backend_b_mac : cfg.backend_a_mac;
				item_c.egress = hash_odd ? lbn_pkg::PORT_BACKEND_B
					: lbn_pkg::PORT_BACKEND_A;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_c;
		end
	end

	assign item = item_s1;

endmodule

// ===== sv/lbn_csum_stage.sv =====
module lbn_csum_stage (
	input  logic                clk,
	input  logic                load,
	input  lbn_pkg::item_t      src,
	input  logic [31:0]         opnd,
	output lbn_pkg::item_t      item
);

	logic [15:0]    ipc_t;
	logic [15:0]    l4c_t;
	lbn_pkg::item_t item_c;
	lbn_pkg::item_t item_q;

	// Fold the low half, then the high half, into both checksums.
	always_comb begin
		ipc_t        = lbn_pkg::oc_add(src.ipc_m, opnd[15:0]);
		l4c_t        = lbn_pkg::oc_add(src.l4c_m, opnd[15:0]);
		item_c       = src;
		item_c.ipc_m = lbn_pkg::oc_add(ipc_t, opnd[31:16]);
		item_c.l4c_m = lbn_pkg::oc_add(l4c_t, opnd[31:16]);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_c;
		end
	end

	assign item = item_q;

endmodule

// ===== sv/l4_hash_load_balancer_nat_core.sv =====
// Stateless L4 load balancer with address rewrite.
// Input channel (in_valid / in_stall): the parsed header fields of one packet
// per item. Output channel (out_valid / out_stall): one verdict item per input
// item, in order: drop flag, egress port and the rewritten MAC, addresses and
// checksums. A dropped item carries its input fields unchanged and port 0.
// Config channel (cfg_valid / cfg_ready): cfg_index selects virtual_ip (0),
// backend_a_ip (1), backend_b_ip (2), backend_a_mac (3), backend_b_mac (4);
// other indexes are ignored. cfg_ready is always high. Write only while no item
// is in flight.
// out_valid rises once an item has reached the last of the register stages below,
// the output register; one item per cycle is sustained while out_stall stays low.
// The three register stages are: classify and backend select,
// fold of the old address into both checksums, fold of the new address.
// When out_stall is high the last stage holds; earlier stages keep moving
// until they fill, so in_stall rises only when all three stages hold items.
// Reset clears the stage valid bits and loads the config registers with their
// default values (10.0.0.1, 10.0.0.2, 10.0.0.3 and the two backend MACs).
module l4_hash_load_balancer_nat_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] frame_length,
	input  logic [7:0]  arrival_port,
	input  logic [47:0] dest_mac,
	input  logic [15:0] ether_type,
	input  logic [7:0]  ip_protocol,
	input  logic [15:0] ip_header_checksum,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	input  logic [15:0] source_port,
	input  logic [15:0] transport_checksum,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        drop,
	output logic [1:0]  egress_port,
	output logic [47:0] new_dest_mac,
	output logic [31:0] new_source_address,
	output logic [31:0] new_destination_address,
	output logic [15:0] new_ip_checksum,
	output logic [15:0] new_transport_checksum,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	lbn_pkg::cfg_t  cfg;
	lbn_pkg::item_t item_s1;
	lbn_pkg::item_t item_s2;
	lbn_pkg::item_t item_s3;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic adv1;
	logic adv2;
	logic adv3;

	assign cfg_ready = 1'b1;

	lbn_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A stage moves when it is empty or its successor moves.
	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: checks, hash parity, backend select, operand setup
	lbn_classify u_classify (
		.clk                 (clk),
		.load                (adv1),
		.cfg                 (cfg),
		.frame_length        (frame_length),
		.arrival_port        (arrival_port),
		.dest_mac            (dest_mac),
		.ether_type          (ether_type),
		.ip_protocol         (ip_protocol),
		.ip_header_checksum  (ip_header_checksum),
		.source_address      (source_address),
		.destination_address (destination_address),
		.source_port         (source_port),
		.transport_checksum  (transport_checksum),
		.item                (item_s1)
	);

	// Stage 2: add back the old address
	lbn_csum_stage u_csum_old (
		.clk  (clk),
		.load (adv2),
		.src  (item_s1),
		.opnd (item_s1.op_a_m),
		.item (item_s2)
	);

	// Stage 3: add the complement of the new address; this is the output register
	lbn_csum_stage u_csum_new (
		.clk  (clk),
		.load (adv3),
		.src  (item_s2),
		.opnd (item_s2.op_b_m),
		.item (item_s3)
	);

	assign out_valid               = valid_s3;
	assign drop                    = item_s3.drop;
	assign egress_port             = item_s3.egress;
	assign new_dest_mac            = item_s3.dmac;
	assign new_source_address      = item_s3.saddr;
	assign new_destination_address = item_s3.daddr;
	assign new_ip_checksum         = lbn_pkg::swap16(item_s3.ipc_m);
	assign new_transport_checksum  = lbn_pkg::swap16(item_s3.l4c_m);

	// An accepted item lands in stage 1.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item missing from stage 1");

	// Back-pressure only when every stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && out_stall)
		else $error("input stalled with a free stage");

	// A dropped item always goes to the client-side port.
	a_drop_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drop |-> egress_port == lbn_pkg::PORT_CLIENT)
		else $error("dropped item with nonzero egress port");

	// Items drain: an unstalled output frees its slot next cycle or refills it.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s2 |=> !out_valid)
		else $error("output item repeated");

endmodule

// ===== sim/lbn_verdict_checker.sv =====
`timescale 1ns / 100ps

module lbn_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] frame_length,
	input  logic [7:0]  arrival_port,
	input  logic [47:0] dest_mac,
	input  logic [15:0] ether_type,
	input  logic [7:0]  ip_protocol,
	input  logic [15:0] ip_header_checksum,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	input  logic [15:0] source_port,
	input  logic [15:0] transport_checksum,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        drop,
	input  logic [1:0]  egress_port,
	input  logic [47:0] new_dest_mac,
	input  logic [31:0] new_source_address,
	input  logic [31:0] new_destination_address,
	input  logic [15:0] new_ip_checksum,
	input  logic [15:0] new_transport_checksum,

	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,

	output int          fail_count,
	output int          pending
);

	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	typedef struct packed {
		logic        drop;
		logic [1:0]  port;
		logic [47:0] mac;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] ipc;
		logic [15:0] l4c;
	} verdict_t;

	logic [31:0] vip, a_ip, b_ip;
	logic [47:0] a_mac, b_mac;

	verdict_t verdicts_due[$];
	int       result_no = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// 16-bit ones' complement add, carry wrapped back in
	function automatic logic [15:0] ec_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Fold an address change into both checksums, all in byte-swapped view
	function automatic void readdress(input logic [31:0] old_a, input logic [31:0] new_a,
			inout logic [15:0] ipc, inout logic [15:0] l4c);
		logic [15:0] ol, oh, nl, nh;
		ol = {old_a[23:16], old_a[31:24]};
		oh = {old_a[7:0], old_a[15:8]};
		nl = {new_a[23:16], new_a[31:24]};
		nh = {new_a[7:0], new_a[15:8]};
		l4c = ec_add(l4c, ol);
		l4c = ec_add(l4c, oh);
		ipc = ec_add(ipc, ol);
		ipc = ec_add(ipc, oh);
		ipc = ec_add(ipc, ~nl);
		ipc = ec_add(ipc, ~nh);
		l4c = ec_add(l4c, ~nl);
		l4c = ec_add(l4c, ~nh);
	endfunction

	function automatic verdict_t predict_verdict();
		verdict_t    v;
		logic        ok;
		logic [15:0] ipc_m, l4c_m;
		logic [31:0] h, nip;
		logic [7:0]  hbytes[7];
		v.drop  = 1'b0;
		v.port  = lbn_pkg::PORT_CLIENT;
		v.mac   = dest_mac;
		v.saddr = source_address;
		v.daddr = destination_address;
		v.ipc   = ip_header_checksum;
		v.l4c   = transport_checksum;
		if (frame_length < lbn_pkg::MIN_LEN_IPV4 || ether_type != lbn_pkg::ETHERTYPE_IPV4)
			ok = 1'b0;
		else if (ip_protocol == lbn_pkg::PROTO_UDP)
			ok = frame_length >= lbn_pkg::MIN_LEN_UDP;
		else if (ip_protocol == lbn_pkg::PROTO_TCP)
			ok = frame_length >= lbn_pkg::MIN_LEN_TCP;
		else
			ok = 1'b0;
		v.drop = !ok;
		if (ok) begin
			ipc_m = {ip_header_checksum[7:0], ip_header_checksum[15:8]};
			l4c_m = {transport_checksum[7:0], transport_checksum[15:8]};
			if (arrival_port != 8'd0) begin
				readdress(source_address, vip, ipc_m, l4c_m);
				v.saddr = vip;
			end else begin
				hbytes = '{source_address[31:24], source_address[23:16],
					source_address[15:8], source_address[7:0],
					source_port[15:8], source_port[7:0], ip_protocol};
				h = 32'd0;
				foreach (hbytes[i])
					h = (h * FNV_PRIME) ^ {24'd0, hbytes[i]};
				nip    = h[0] ? b_ip : a_ip;
				v.mac  = h[0] ? b_mac : a_mac;
				v.port = h[0] ? lbn_pkg::PORT_BACKEND_B : lbn_pkg::PORT_BACKEND_A;
				readdress(destination_address, nip, ipc_m, l4c_m);
				v.daddr = nip;
			end
			v.ipc = {ipc_m[7:0], ipc_m[15:8]};
			v.l4c = {l4c_m[7:0], l4c_m[15:8]};
		end
		return v;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [47:0] got,
			input logic [47:0] want);
		if (got !== want)
			report($sformatf("result %0d %s got %h expected %h", result_no, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			vip   = lbn_pkg::RST_VIRTUAL_IP;
			a_ip  = lbn_pkg::RST_BACKEND_A_IP;
			b_ip  = lbn_pkg::RST_BACKEND_B_IP;
			a_mac = lbn_pkg::RST_BACKEND_A_MAC;
			b_mac = lbn_pkg::RST_BACKEND_B_MAC;
			verdicts_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lbn_pkg::CFG_VIRTUAL_IP:    vip   = cfg_data[31:0];
					lbn_pkg::CFG_BACKEND_A_IP:  a_ip  = cfg_data[31:0];
					lbn_pkg::CFG_BACKEND_B_IP:  b_ip  = cfg_data[31:0];
					lbn_pkg::CFG_BACKEND_A_MAC: a_mac = cfg_data;
					lbn_pkg::CFG_BACKEND_B_MAC: b_mac = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					report($sformatf("result %0d arrived with none due", result_no));
				end else begin
					want = verdicts_due.pop_front();
					check_field("drop", 48'(drop), 48'(want.drop));
					check_field("egress_port", 48'(egress_port), 48'(want.port));
					check_field("new_dest_mac", new_dest_mac, want.mac);
					check_field("new_source_address", 48'(new_source_address),
						48'(want.saddr));
					check_field("new_destination_address", 48'(new_destination_address),
						48'(want.daddr));
					check_field("new_ip_checksum", 48'(new_ip_checksum), 48'(want.ipc));
					check_field("new_transport_checksum", 48'(new_transport_checksum),
						48'(want.l4c));
				end
				result_no++;
			end
			if (in_valid && !in_stall)
				verdicts_due.push_back(predict_verdict());
			pending = verdicts_due.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

	// Pipeline depth of the block, plus slack used before config writes and at the end
	localparam int          PIPE_LATENCY = 3;
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          PHASE_ITEMS  = 210;
	localparam logic [15:0] MTU_FRAME    = 16'd1514;
	localparam logic [15:0] MIN_LEN_ETH  = 16'd14;
	// Register indexes the block must ignore
	localparam logic [2:0]  CFG_SPARE_LO = 3'd5;
	localparam logic [2:0]  CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [15:0] flen;
		logic [7:0]  iport;
		logic [47:0] dmac;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [15:0] ipck;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] l4ck;
	} pkt_t;

	logic        clk;
	logic        arst_n;

	logic        in_valid;
	logic        in_stall;
	logic [15:0] frame_length;
	logic [7:0]  arrival_port;
	logic [47:0] dest_mac;
	logic [15:0] ether_type;
	logic [7:0]  ip_protocol;
	logic [15:0] ip_header_checksum;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [15:0] source_port;
	logic [15:0] transport_checksum;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        drop;
	logic [1:0]  egress_port;
	logic [47:0] new_dest_mac;
	logic [31:0] new_source_address;
	logic [31:0] new_destination_address;
	logic [15:0] new_ip_checksum;
	logic [15:0] new_transport_checksum;

	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	int fail_count;
	int pending;
	int cycles = 0;

	// Idle controls: when set, that side never waits
	bit tx_no_idle = 1'b0;
	bit rx_no_idle = 1'b0;
	bit rx_took    = 1'b0;
	int rx_hold    = 0;

	l4_hash_load_balancer_nat_core DUT (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.frame_length            (frame_length),
		.arrival_port            (arrival_port),
		.dest_mac                (dest_mac),
		.ether_type              (ether_type),
		.ip_protocol             (ip_protocol),
		.ip_header_checksum      (ip_header_checksum),
		.source_address          (source_address),
		.destination_address     (destination_address),
		.source_port             (source_port),
		.transport_checksum      (transport_checksum),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.drop                    (drop),
		.egress_port             (egress_port),
		.new_dest_mac            (new_dest_mac),
		.new_source_address      (new_source_address),
		.new_destination_address (new_destination_address),
		.new_ip_checksum         (new_ip_checksum),
		.new_transport_checksum  (new_transport_checksum),
		.cfg_valid               (cfg_valid),
		.cfg_ready               (cfg_ready),
		.cfg_index               (cfg_index),
		.cfg_data                (cfg_data)
	);

	lbn_verdict_checker CHK (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.frame_length            (frame_length),
		.arrival_port            (arrival_port),
		.dest_mac                (dest_mac),
		.ether_type              (ether_type),
		.ip_protocol             (ip_protocol),
		.ip_header_checksum      (ip_header_checksum),
		.source_address          (source_address),
		.destination_address     (destination_address),
		.source_port             (source_port),
		.transport_checksum      (transport_checksum),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.drop                    (drop),
		.egress_port             (egress_port),
		.new_dest_mac            (new_dest_mac),
		.new_source_address      (new_source_address),
		.new_destination_address (new_destination_address),
		.new_ip_checksum         (new_ip_checksum),
		.new_transport_checksum  (new_transport_checksum),
		.cfg_valid               (cfg_valid),
		.cfg_ready               (cfg_ready),
		.cfg_index               (cfg_index),
		.cfg_data                (cfg_data),
		.fail_count              (fail_count),
		.pending                 (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: after each accepted result, draw a random stall length, possibly zero
	always @(posedge clk)
		rx_took <= arst_n && out_valid && !out_stall;

	always @(negedge clk) begin
		int draw;
		if (rx_took) begin
			draw      = rx_no_idle ? 0 : $urandom_range(0, 11);
			out_stall <= draw != 0;
			rx_hold   <= (draw != 0) ? draw - 1 : 0;
		end else if (rx_hold != 0) begin
			out_stall <= 1'b1;
			rx_hold   <= rx_hold - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	// Well-formed packet: IPv4, given protocol and ingress port, long enough
	function automatic pkt_t good_pkt(input logic [7:0] proto, input logic [7:0] iport);
		pkt_t        p;
		logic [15:0] min_len;
		min_len = (proto == lbn_pkg::PROTO_TCP) ? lbn_pkg::MIN_LEN_TCP : lbn_pkg::MIN_LEN_UDP;
		p.flen  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(min_len, 16'hFFFF))
			: 16'($urandom_range(min_len, MTU_FRAME));
		p.iport = iport;
		p.dmac  = rand_mac();
		p.etype = lbn_pkg::ETHERTYPE_IPV4;
		p.proto = proto;
		p.ipck  = 16'($urandom());
		p.saddr = $urandom();
		p.daddr = $urandom();
		p.sport = 16'($urandom());
		p.l4ck  = 16'($urandom());
		return p;
	endfunction

	// Mostly well-formed traffic; the rest sits near the length limits or is noise
	function automatic pkt_t rand_pkt();
		pkt_t       p;
		int         kind;
		logic [7:0] proto, iport;
		kind  = $urandom_range(0, 99);
		proto = $urandom_range(0, 1) ? lbn_pkg::PROTO_TCP : lbn_pkg::PROTO_UDP;
		iport = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
		p     = good_pkt(proto, iport);
		if (kind >= 75 && kind < 88) begin
			p.flen = 16'($urandom_range(0, lbn_pkg::MIN_LEN_TCP + 4));
			if ($urandom_range(0, 3) == 0)
				p.proto = 8'($urandom());
		end else if (kind >= 88) begin
			p.flen  = 16'($urandom());
			p.etype = $urandom_range(0, 1) ? lbn_pkg::ETHERTYPE_IPV4 : 16'($urandom());
			if ($urandom_range(0, 1))
				p.proto = 8'($urandom());
		end
		if ($urandom_range(0, 19) == 0)
			p.l4ck = 16'd0;
		return p;
	endfunction

	// Present one item, then hold it until the block takes it
	task automatic send_pkt(input pkt_t p);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		frame_length        <= p.flen;
		arrival_port        <= p.iport;
		dest_mac            <= p.dmac;
		ether_type          <= p.etype;
		ip_protocol         <= p.proto;
		ip_header_checksum  <= p.ipck;
		source_address      <= p.saddr;
		destination_address <= p.daddr;
		source_port         <= p.sport;
		transport_checksum  <= p.l4ck;
		in_valid            <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram all five registers; only called with the pipe drained
	task automatic set_all(input logic [31:0] vip, input logic [31:0] aip,
			input logic [31:0] bip, input logic [47:0] amac, input logic [47:0] bmac);
		wait_idle();
		repeat (PIPE_LATENCY + 2) @(negedge clk);
		write_reg(lbn_pkg::CFG_VIRTUAL_IP, {16'd0, vip});
		write_reg(lbn_pkg::CFG_BACKEND_A_IP, {16'd0, aip});
		write_reg(lbn_pkg::CFG_BACKEND_B_IP, {16'd0, bip});
		write_reg(lbn_pkg::CFG_BACKEND_A_MAC, amac);
		write_reg(lbn_pkg::CFG_BACKEND_B_MAC, bmac);
	endtask

	task automatic run_random(input int n);
		repeat (n) send_pkt(rand_pkt());
	endtask

	initial begin
		pkt_t p;

		// Drive every input to a known value before the first edge
		arst_n              = 1'b0;
		in_valid            = 1'b0;
		frame_length        = '0;
		arrival_port        = '0;
		dest_mac            = '0;
		ether_type          = '0;
		ip_protocol         = '0;
		ip_header_checksum  = '0;
		source_address      = '0;
		destination_address = '0;
		source_port         = '0;
		transport_checksum  = '0;
		cfg_valid           = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values
		// Length checks at and around every threshold
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.flen = 16'd0; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.flen = MIN_LEN_ETH - 16'd1; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.flen = MIN_LEN_ETH; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0);
		p.flen = lbn_pkg::MIN_LEN_IPV4 - 16'd1; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.flen = lbn_pkg::MIN_LEN_IPV4; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd3);
		p.flen = lbn_pkg::MIN_LEN_UDP - 16'd1; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.flen = lbn_pkg::MIN_LEN_UDP; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0);
		p.flen = lbn_pkg::MIN_LEN_TCP - 16'd1; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0); p.flen = lbn_pkg::MIN_LEN_TCP; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd1); p.flen = 16'hFFFF; send_pkt(p);
		// Wrong ethertype, including IPv4 in the wrong byte order, and one too short too
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0); p.etype = 16'h0000; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0); p.etype = 16'hFFFF; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.etype = 16'h0008; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.etype = 16'h86DD; p.flen = 16'd13;
		send_pkt(p);
		// Protocols other than TCP and UDP
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.proto = 8'd0; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd2); p.proto = 8'hFF; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0); p.proto = 8'd1; send_pkt(p);
		// Any nonzero ingress port is server side
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'hFF); send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'h80); p.dmac = '1; send_pkt(p);
		// Zero UDP checksum gets updated like any other value
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd0); p.l4ck = 16'd0; send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd7); p.l4ck = 16'd0; send_pkt(p);
		// All-ones and all-zeros header fields on the client side, then a mix on the server side
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0);
		p.saddr = '1; p.daddr = '1; p.sport = '1; p.ipck = '1; p.l4ck = '1; p.dmac = '1;
		send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_TCP, 8'd0);
		p.saddr = '0; p.daddr = '0; p.sport = '0; p.ipck = '0; p.l4ck = '0; p.dmac = '0;
		send_pkt(p);
		p = good_pkt(lbn_pkg::PROTO_UDP, 8'd1);
		p.saddr = '1; p.ipck = '0; p.l4ck = '1;
		send_pkt(p);

		// Phase 0: reset registers, both sides idle at random
		run_random(PHASE_ITEMS);

		// Phase 1: random registers, full rate on both sides
		set_all($urandom(), $urandom(), $urandom(), rand_mac(), rand_mac());
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		run_random(PHASE_ITEMS);

		// Phase 2: all zeros; hold the sender once mid-phase until the pipe drains
		set_all('0, '0, '0, '0, '0);
		tx_no_idle = 1'b0;
		run_random(PHASE_ITEMS / 2);
		wait_idle();
		run_random(PHASE_ITEMS / 2);

		// Phase 3: all ones, receiver idles at random
		set_all('1, '1, '1, '1, '1);
		rx_no_idle = 1'b0;
		run_random(PHASE_ITEMS);

		// Phase 4: random registers, then writes to spare indexes that must change nothing;
		// the sender runs flat out into a stalling receiver
		set_all($urandom(), $urandom(), $urandom(), rand_mac(), rand_mac());
		repeat (4) write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), rand_mac());
		tx_no_idle = 1'b1;
		run_random(PHASE_ITEMS);

		// Phase 5: mixed extremes
		set_all('0, '1, $urandom(), '1, '0);
		tx_no_idle = 1'b0;
		run_random(PHASE_ITEMS);

		// Drain, then give any stray result a chance to show up
		wait_idle();
		repeat (PIPE_LATENCY + 8) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
